/* rtl/core/kps2_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps2_pkg: shared types and constants for the PS/2 Set 2 encoder
// Queue geometry, prefix bytes, key ROM lookup, sequencer states.
// ----------------------------------------------------------------------------
package kps2_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] PREFIX_EXT   = 8'hE0;
  localparam logic [7:0] PREFIX_BREAK = 8'hF0;

  typedef enum logic [0:0] {
    CMD_KEY  = 1'b0,
    CMD_READ = 1'b1
  } kps2_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_PUSH,
    ST_READ,
    ST_DONE
  } kps2_state_t;

  typedef struct packed {
    logic       known;
    logic       ext;
    logic [7:0] make;
  } kps2_key_info_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wdata;
  } kps2_fifo_ctl_t;

  // Linux key code -> Set 2 make code, extended flag
  function automatic kps2_key_info_t key_lookup(input logic [9:0] code);
    kps2_key_info_t r;
    r = '{known: 1'b1, ext: 1'b0, make: 8'h00};
    case (code)
      10'd16:  r.make = 8'h15;
      10'd17:  r.make = 8'h1D;
      10'd18:  r.make = 8'h24;
      10'd19:  r.make = 8'h2D;
      10'd20:  r.make = 8'h2C;
      10'd21:  r.make = 8'h35;
      10'd22:  r.make = 8'h3C;
      10'd23:  r.make = 8'h43;
      10'd24:  r.make = 8'h44;
      10'd25:  r.make = 8'h4D;
      10'd30:  r.make = 8'h1C;
      10'd31:  r.make = 8'h1B;
      10'd32:  r.make = 8'h23;
      10'd33:  r.make = 8'h2B;
      10'd34:  r.make = 8'h34;
      10'd35:  r.make = 8'h33;
      10'd36:  r.make = 8'h3B;
      10'd37:  r.make = 8'h42;
      10'd38:  r.make = 8'h4B;
      10'd44:  r.make = 8'h1A;
      10'd45:  r.make = 8'h22;
      10'd46:  r.make = 8'h21;
      10'd47:  r.make = 8'h2A;
      10'd48:  r.make = 8'h32;
      10'd49:  r.make = 8'h31;
      10'd50:  r.make = 8'h3A;
      10'd2:   r.make = 8'h16;
      10'd3:   r.make = 8'h1E;
      10'd4:   r.make = 8'h26;
      10'd5:   r.make = 8'h25;
      10'd6:   r.make = 8'h2E;
      10'd7:   r.make = 8'h36;
      10'd8:   r.make = 8'h3D;
      10'd9:   r.make = 8'h3E;
      10'd10:  r.make = 8'h46;
      10'd11:  r.make = 8'h45;
      10'd12:  r.make = 8'h4E;
      10'd13:  r.make = 8'h55;
      10'd26:  r.make = 8'h54;
      10'd27:  r.make = 8'h5B;
      10'd39:  r.make = 8'h4C;
      10'd40:  r.make = 8'h52;
      10'd51:  r.make = 8'h41;
      10'd52:  r.make = 8'h49;
      10'd53:  r.make = 8'h4A;
      10'd1:   r.make = 8'h76;
      10'd14:  r.make = 8'h66;
      10'd15:  r.make = 8'h0D;
      10'd28:  r.make = 8'h5A;
      10'd57:  r.make = 8'h29;
      10'd42:  r.make = 8'h12;
      10'd54:  r.make = 8'h59;
      10'd29:  r.make = 8'h14;
      10'd97:  begin r.make = 8'h14; r.ext = 1'b1; end
      10'd56:  r.make = 8'h11;
      10'd100: begin r.make = 8'h11; r.ext = 1'b1; end
      10'd59:  r.make = 8'h05;
      10'd60:  r.make = 8'h06;
      10'd61:  r.make = 8'h04;
      10'd62:  r.make = 8'h0C;
      10'd63:  r.make = 8'h03;
      10'd64:  r.make = 8'h0B;
      10'd65:  r.make = 8'h83;
      10'd66:  r.make = 8'h0A;
      10'd67:  r.make = 8'h01;
      10'd68:  r.make = 8'h09;
      10'd87:  r.make = 8'h78;
      10'd88:  r.make = 8'h07;
      10'd103: begin r.make = 8'h75; r.ext = 1'b1; end
      10'd108: begin r.make = 8'h72; r.ext = 1'b1; end
      10'd105: begin r.make = 8'h6B; r.ext = 1'b1; end
      10'd106: begin r.make = 8'h74; r.ext = 1'b1; end
      default: r.known = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/keycode_to_ps2_set2_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keycode_to_ps2_set2_fifo: key event to PS/2 Set 2 byte queue
// Encodes key events into Set 2 byte sequences and serves byte reads.
// ----------------------------------------------------------------------------
// Usage:
//   Command port: drive in_cmd / in_key_code / in_release_req and pulse start
//   while busy is low; the item is taken on that edge and busy rises.
//   in_cmd = key event: the code is looked up in the key ROM; a known key
//   queues [E0] [F0] make as one unit, or nothing if the whole sequence does
//   not fit (out_overflow). in_cmd = read: pops one byte, or 0 if empty.
//   Result: out_strobe is high for exactly one cycle with all out_ fields;
//   the receiver cannot stall, so the result is simply dropped if unused.
// Sequencing:
//   Read: accept, the READ state pops the queue, DONE gives the result.
//   Key event: the LOOKUP state, then one queued byte (0..3 in all) per
//   cycle on the single queue write port in PUSH, then DONE gives the result.
//   busy holds new items off until IDLE; the queue write port sets the key rate.
// Reset: synchronous rst_n empties the queue (pointers and count to zero)
//   and returns the sequencer to idle; queue contents are left as they are.
// ----------------------------------------------------------------------------
module keycode_to_ps2_set2_fifo (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_cmd,
  input  logic [9:0] in_key_code,
  input  logic       in_release_req,
  output logic       out_strobe,
  output logic [7:0] out_read_byte,
  output logic       out_byte_valid,
  output logic       out_key_known,
  output logic       out_overflow,
  output logic [5:0] out_fill_level
);

  kps2_pkg::kps2_state_t state_r, state_nxt;

  logic       cmd_r, cmd_nxt;
  logic [9:0] code_r, code_nxt;
  logic       rel_r, rel_nxt;
  logic [7:0] make_r, make_nxt;
  logic       pend_ext_r, pend_ext_nxt;   // E0 still to write
  logic       pend_rel_r, pend_rel_nxt;   // F0 still to write
  logic       known_r, known_nxt;
  logic       ovf_r, ovf_nxt;
  logic       valid_r, valid_nxt;

  kps2_pkg::kps2_fifo_ctl_t    fifo_ctl;
  logic [7:0]                  fifo_rd_data;
  logic [kps2_pkg::CNT_W-1:0]  fifo_count;

  kps2_pkg::kps2_key_info_t    info;
  logic [1:0]                  need;
  logic [kps2_pkg::CNT_W:0]    fill_after;
  logic                        fits;

  kps2_byte_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (fifo_ctl),
    .rd_data (fifo_rd_data),
    .count   (fifo_count)
  );

  // lookup and room check, used in the lookup cycle only
  always_comb begin
    info       = kps2_pkg::key_lookup(code_r);
    need       = 2'd1 + {1'b0, info.ext} + {1'b0, rel_r};
    fill_after = {1'b0, fifo_count} + (kps2_pkg::CNT_W+1)'(need);
    fits       = (fill_after <= (kps2_pkg::CNT_W+1)'(kps2_pkg::QUEUE_DEPTH));
  end

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    code_nxt     = code_r;
    rel_nxt      = rel_r;
    make_nxt     = make_r;
    pend_ext_nxt = pend_ext_r;
    pend_rel_nxt = pend_rel_r;
    known_nxt    = known_r;
    ovf_nxt      = ovf_r;
    valid_nxt    = valid_r;
    fifo_ctl     = '{push: 1'b0, pop: 1'b0, wdata: 8'h00};

    case (state_r)
      kps2_pkg::ST_IDLE: begin
        if (start) begin
          cmd_nxt   = in_cmd;
          code_nxt  = in_key_code;
          rel_nxt   = in_release_req;
          known_nxt = 1'b0;
          ovf_nxt   = 1'b0;
          valid_nxt = 1'b0;
          state_nxt = (in_cmd == kps2_pkg::CMD_READ) ? kps2_pkg::ST_READ
                                                      : kps2_pkg::ST_LOOKUP;
        end
      end
      kps2_pkg::ST_LOOKUP: begin
        known_nxt    = info.known;
        ovf_nxt      = info.known && !fits;
        make_nxt     = info.make;
        pend_ext_nxt = info.ext;
        pend_rel_nxt = rel_r;
        state_nxt    = (info.known && fits) ? kps2_pkg::ST_PUSH : kps2_pkg::ST_DONE;
      end
      kps2_pkg::ST_PUSH: begin
        fifo_ctl.push = 1'b1;
        if (pend_ext_r) begin
          fifo_ctl.wdata = kps2_pkg::PREFIX_EXT;
          pend_ext_nxt   = 1'b0;
        end else if (pend_rel_r) begin
          fifo_ctl.wdata = kps2_pkg::PREFIX_BREAK;
          pend_rel_nxt   = 1'b0;
        end else begin
          fifo_ctl.wdata = make_r;
          state_nxt      = kps2_pkg::ST_DONE;
        end
      end
      kps2_pkg::ST_READ: begin
        fifo_ctl.pop = (fifo_count != '0);
        valid_nxt    = (fifo_count != '0);
        state_nxt    = kps2_pkg::ST_DONE;
      end
      kps2_pkg::ST_DONE: begin
        state_nxt = kps2_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = kps2_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= kps2_pkg::ST_IDLE;
      pend_ext_r <= 1'b0;
      pend_rel_r <= 1'b0;
      known_r    <= 1'b0;
      ovf_r      <= 1'b0;
      valid_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pend_ext_r <= pend_ext_nxt;
      pend_rel_r <= pend_rel_nxt;
      known_r    <= known_nxt;
      ovf_r      <= ovf_nxt;
      valid_r    <= valid_nxt;
    end
  end

  // item payload, no reset needed
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    code_r <= code_nxt;
    rel_r  <= rel_nxt;
    make_r <= make_nxt;
  end

  assign busy           = (state_r != kps2_pkg::ST_IDLE);
  assign out_strobe     = (state_r == kps2_pkg::ST_DONE);
  // popped byte sits in the queue's read register until the next pop
  assign out_read_byte  = valid_r ? fifo_rd_data : 8'h00;
  assign out_byte_valid = valid_r;
  assign out_key_known  = known_r && (cmd_r == kps2_pkg::CMD_KEY);
  assign out_overflow   = ovf_r && (cmd_r == kps2_pkg::CMD_KEY);
  assign out_fill_level = 6'(fifo_count);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_count_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_count <= kps2_pkg::CNT_W'(kps2_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_strobe))
    else $error("accepted item did not raise busy");

  a_one_result_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> (!out_strobe && !busy))
    else $error("result strobe longer than one cycle");

  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (!(out_byte_valid && out_key_known) &&
                    (!out_overflow || out_key_known)))
    else $error("inconsistent result flags");

  a_overflow_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_overflow) |-> (fifo_count == $past(fifo_count)))
    else $error("dropped sequence changed the queue");

endmodule

/* rtl/core/kps2_byte_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps2_byte_fifo: scan code byte queue
// Single write port, registered read port, wrap pointers and fill count.
// ----------------------------------------------------------------------------
module kps2_byte_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  kps2_pkg::kps2_fifo_ctl_t  ctl,
  output logic [7:0]                rd_data,
  output logic [kps2_pkg::CNT_W-1:0] count
);

  logic [7:0]                 mem [kps2_pkg::QUEUE_DEPTH];
  logic [7:0]                 rd_data_r;
  logic [kps2_pkg::IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [kps2_pkg::IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [kps2_pkg::CNT_W-1:0] count_r, count_nxt;

  localparam logic [kps2_pkg::IDX_W-1:0] LAST_IDX = kps2_pkg::IDX_W'(kps2_pkg::QUEUE_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr_r] <= ctl.wdata;
    end
    if (ctl.pop) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (ctl.push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (ctl.pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({ctl.push, ctl.pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign rd_data = rd_data_r;
  assign count   = count_r;

endmodule
